// ----- hdl/dual_axis_pwm_accel_decoder_core_macros.svh -----
// Assertion helpers. They expect i_clk and i_rst_n in the calling scope.
`ifndef DUAL_AXIS_PWM_ACCEL_DECODER_CORE_MACROS_SVH
`define DUAL_AXIS_PWM_ACCEL_DECODER_CORE_MACROS_SVH

`ifndef SYNTH

`define DAPAD_ASSERT(label, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("dapad: check failed");

`define DAPAD_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("dapad: check failed");

`define DAPAD_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("dapad: check failed");

`else

`define DAPAD_ASSERT(label, cond)
`define DAPAD_ASSERT_IMP(label, ante, cons)
`define DAPAD_ASSERT_NXT(label, ante, cons)

`endif

`endif

// ----- hdl/dapad_pkg.sv -----
`default_nettype none

package dapad_pkg;

    localparam int TS_W = 16;

    // op codes of an input beat; the fourth code is unused
    localparam logic [1:0] OP_START_MEAS = 2'd0;
    localparam logic [1:0] OP_START_CAL  = 2'd1;
    localparam logic [1:0] OP_EDGE       = 2'd2;

    localparam logic CH_X = 1'b0;

    // bit positions in the armed mask
    localparam int ARM_X = 0;
    localparam int ARM_Y = 1;

    typedef struct packed {
        logic [1:0]      op;
        logic            channel;
        logic            level;
        logic [TS_W-1:0] timestamp;
    } t_evt;

    typedef struct packed {
        logic [TS_W-1:0] x_width;
        logic [TS_W-1:0] y_width;
        logic [TS_W-1:0] period;
        logic [TS_W-1:0] zero_x;
        logic [TS_W-1:0] zero_y;
        logic [TS_W-1:0] zero_period;
        logic            calibrating;
        logic            calibrated;
    } t_res;

    typedef struct packed {
        logic [TS_W-1:0] x_width;
        logic [TS_W-1:0] y_width;
        logic [TS_W-1:0] period;
    } t_sample;

    typedef struct packed {
        logic [TS_W-1:0] x;
        logic [TS_W-1:0] y;
        logic [TS_W-1:0] period;
    } t_zero;

    typedef struct packed {
        logic start;    // begin a calibration run
        logic done;     // a measurement completes this cycle
    } t_cal_ctrl;

    typedef struct packed {
        logic active;   // run in progress before this cycle
        logic n_active; // run in progress after this cycle
        logic n_valid;  // offsets hold an average after this cycle
    } t_cal_stat;

endpackage

`default_nettype wire

// ----- hdl/dapad_stream_if.sv -----
`default_nettype none

interface dapad_stream_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- hdl/dapad_cal.sv -----
`default_nettype none
`include "dual_axis_pwm_accel_decoder_core_macros.svh"

module dapad_cal
    import dapad_pkg::*;
#(
    parameter int CAL_SAMPLES = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cal_ctrl i_ctrl,
    input  t_sample   i_smp,
    output t_cal_stat o_stat,
    output t_zero     o_zero
);

    localparam int LOG_N    = $clog2(CAL_SAMPLES);
    localparam int SUM_W    = TS_W + LOG_N;
    localparam int CNT_W    = $clog2(CAL_SAMPLES + 1);
    localparam int PROD_W   = 2 * SUM_W + 1;
    localparam int RECIP_SH = SUM_W + LOG_N;
    // ceil(2^RECIP_SH / N): exact quotient for every sum below 2^SUM_W
    localparam logic [SUM_W:0] RECIP = (SUM_W + 1)'(
        ((64'd1 << RECIP_SH) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES));

    function automatic logic [TS_W-1:0] div_n(input logic [SUM_W-1:0] s);
        logic [PROD_W-1:0] p;
        p = PROD_W'(s) * PROD_W'(RECIP);
        return p[RECIP_SH +: TS_W];
    endfunction

    logic [SUM_W-1:0] r_sum_x, r_sum_y, r_sum_p;
    logic [SUM_W-1:0] n_sum_x, n_sum_y, n_sum_p;
    logic [SUM_W-1:0] add_x, add_y, add_p;
    logic [CNT_W-1:0] r_cnt, n_cnt, cnt_inc;
    logic             r_active, n_active;
    logic             r_valid, n_valid;
    t_zero            r_off, n_off;
    logic             absorb;
    logic             last;

    assign absorb  = i_ctrl.done && r_active;
    assign add_x   = r_sum_x + SUM_W'(i_smp.x_width);
    assign add_y   = r_sum_y + SUM_W'(i_smp.y_width);
    assign add_p   = r_sum_p + SUM_W'(i_smp.period);
    assign cnt_inc = r_cnt + CNT_W'(1);
    assign last    = cnt_inc >= CNT_W'(CAL_SAMPLES);

    always_comb begin
        n_sum_x  = r_sum_x;
        n_sum_y  = r_sum_y;
        n_sum_p  = r_sum_p;
        n_cnt    = r_cnt;
        n_active = r_active;
        n_valid  = r_valid;
        n_off    = r_off;
        if (i_ctrl.start) begin
            n_sum_x  = '0;
            n_sum_y  = '0;
            n_sum_p  = '0;
            n_cnt    = '0;
            n_active = 1'b1;
        end else if (absorb) begin
            n_sum_x = add_x;
            n_sum_y = add_y;
            n_sum_p = add_p;
            n_cnt   = cnt_inc;
            if (last) begin
                n_off.x      = div_n(add_x);
                n_off.y      = div_n(add_y);
                n_off.period = div_n(add_p);
                n_valid      = 1'b1;
                n_active     = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_x  <= '0;
            r_sum_y  <= '0;
            r_sum_p  <= '0;
            r_cnt    <= '0;
            r_active <= 1'b0;
            r_valid  <= 1'b0;
            r_off    <= '0;
        end else begin
            r_sum_x  <= n_sum_x;
            r_sum_y  <= n_sum_y;
            r_sum_p  <= n_sum_p;
            r_cnt    <= n_cnt;
            r_active <= n_active;
            r_valid  <= n_valid;
            r_off    <= n_off;
        end
    end

    assign o_stat.active   = r_active;
    assign o_stat.n_active = n_active;
    assign o_stat.n_valid  = n_valid;
    assign o_zero          = n_off;

    `DAPAD_ASSERT(a_cnt_bound, r_cnt <= CNT_W'(CAL_SAMPLES))
    `DAPAD_ASSERT_IMP(a_active_cnt, r_active, r_cnt < CNT_W'(CAL_SAMPLES))
    `DAPAD_ASSERT_NXT(a_valid_sticky, r_valid, r_valid)

endmodule

`default_nettype wire

// ----- hdl/dual_axis_pwm_accel_decoder_core.sv -----
// Channel | Dir | Beat                                       | Accepted when
// i_evt   | in  | op, channel, level, timestamp              | valid && ready
// o_res   | out | widths, period, zero offsets, cal status   | valid && ready
//
// One event per cycle unless stalled. An event waits in the input register,
// then updates the edge tracker and, on a Y fall, loads the result register.
// Input stalls only when a completing Y fall waits on a full, stalled result.
// Synchronous active-low reset clears all tracking and calibration state.
`default_nettype none
`include "dual_axis_pwm_accel_decoder_core_macros.svh"

module dual_axis_pwm_accel_decoder_core
    import dapad_pkg::*;
#(
    parameter int CAL_SAMPLES = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    dapad_stream_if.sink          i_evt,
    dapad_stream_if.source        o_res
);

    t_evt            r_in;
    logic            r_in_vld;
    t_res            r_out;
    logic            r_out_vld;

    logic [1:0]      r_armed, n_armed;
    logic            r_seen, n_seen;
    logic [TS_W-1:0] r_x_rise, n_x_rise;
    logic [TS_W-1:0] r_y_rise, n_y_rise;
    logic [TS_W-1:0] r_x_ctr, n_x_ctr;   // X pulse center
    logic [TS_W-1:0] r_x_len, n_x_len;

    logic            is_edge, x_hit, y_hit, y_done;
    logic            out_free, adv, step;
    logic [TS_W-1:0] x_len_new, x_ctr_new, y_width, period;

    t_cal_ctrl       cal_ctrl;
    t_cal_stat       cal_stat;
    t_sample         smp;
    t_zero           zero;

    assign is_edge = r_in.op == OP_EDGE;
    assign x_hit   = is_edge && (r_in.channel == CH_X) && r_armed[ARM_X];
    assign y_hit   = is_edge && (r_in.channel != CH_X) && r_armed[ARM_Y];
    assign y_done  = y_hit && !r_in.level && r_seen;

    assign out_free    = !r_out_vld || o_res.ready;
    assign adv         = !y_done || out_free;
    assign step        = r_in_vld && adv;
    assign i_evt.ready = !r_in_vld || adv;

    assign x_len_new = r_in.timestamp - r_x_rise;
    assign x_ctr_new = r_in.timestamp - {1'b0, x_len_new[TS_W-1:1]};
    assign y_width   = r_in.timestamp - r_y_rise;
    assign period    = r_in.timestamp - {1'b0, y_width[TS_W-1:1]} - r_x_ctr;

    assign cal_ctrl.start = step && (r_in.op == OP_START_CAL);
    assign cal_ctrl.done  = step && y_done;
    assign smp.x_width    = r_x_len;
    assign smp.y_width    = y_width;
    assign smp.period     = period;

    dapad_cal #(
        .CAL_SAMPLES (CAL_SAMPLES)
    ) u_cal (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (cal_ctrl),
        .i_smp   (smp),
        .o_stat  (cal_stat),
        .o_zero  (zero)
    );

    always_comb begin
        n_armed  = r_armed;
        n_seen   = r_seen;
        n_x_rise = r_x_rise;
        n_y_rise = r_y_rise;
        n_x_ctr  = r_x_ctr;
        n_x_len  = r_x_len;
        if (step) begin
            if (r_in.op == OP_START_MEAS || r_in.op == OP_START_CAL) begin
                n_armed[ARM_X] = 1'b1;
            end else if (x_hit) begin
                if (r_in.level) begin
                    n_x_rise = r_in.timestamp;
                    n_seen   = 1'b1;
                end else if (r_seen) begin
                    n_x_len        = x_len_new;
                    n_x_ctr        = x_ctr_new;
                    n_seen         = 1'b0;
                    n_armed[ARM_X] = 1'b0;
                    n_armed[ARM_Y] = 1'b1;
                end
            end else if (y_hit) begin
                if (r_in.level) begin
                    n_y_rise = r_in.timestamp;
                    n_seen   = 1'b1;
                end else if (r_seen) begin
                    n_seen         = 1'b0;
                    n_armed[ARM_Y] = 1'b0;
                    // each calibration sample re-arms X
                    if (cal_stat.active) begin
                        n_armed[ARM_X] = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_armed   <= '0;
            r_seen    <= 1'b0;
            r_x_rise  <= '0;
            r_y_rise  <= '0;
            r_x_ctr   <= '0;
            r_x_len   <= '0;
        end else begin
            if (i_evt.valid && i_evt.ready) begin
                r_in_vld <= 1'b1;
            end else if (step) begin
                r_in_vld <= 1'b0;
            end
            if (step && y_done) begin
                r_out_vld <= 1'b1;
            end else if (o_res.ready) begin
                r_out_vld <= 1'b0;
            end
            r_armed  <= n_armed;
            r_seen   <= n_seen;
            r_x_rise <= n_x_rise;
            r_y_rise <= n_y_rise;
            r_x_ctr  <= n_x_ctr;
            r_x_len  <= n_x_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_evt.valid && i_evt.ready) begin
            r_in <= i_evt.data;
        end
        if (step && y_done) begin
            r_out.x_width     <= r_x_len;
            r_out.y_width     <= y_width;
            r_out.period      <= period;
            r_out.zero_x      <= zero.x;
            r_out.zero_y      <= zero.y;
            r_out.zero_period <= zero.period;
            r_out.calibrating <= cal_stat.n_active;
            r_out.calibrated  <= cal_stat.n_valid;
        end
    end

    assign o_res.valid = r_out_vld;
    assign o_res.data  = r_out;

    `DAPAD_ASSERT_IMP(a_stall_cause, !i_evt.ready, r_in_vld && r_out_vld && y_done)
    `DAPAD_ASSERT_NXT(a_result_load, step && y_done, r_out_vld)
    `DAPAD_ASSERT_NXT(a_in_hold, r_in_vld && !adv, r_in_vld && $stable(r_in))

endmodule

`default_nettype wire
